// ===== hw/rtl/hsv2rgb_pkg.sv =====
// Shared types and constants for the HSV to RGB pixel core.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hsv2rgb_pkg;

    localparam int HUE_W    = 15;
    localparam int CH_W     = 8;
    localparam int PACK_W   = 3 * CH_W;
    localparam int CHAN_MAX = 255;
    localparam int SECT_DEG = 60;
    localparam int NUM_SECT = 6;

    // Hue sector; anything past the sixth sector renders black.
    typedef enum logic [2:0] {
        SEC_0     = 3'd0,
        SEC_1     = 3'd1,
        SEC_2     = 3'd2,
        SEC_3     = 3'd3,
        SEC_4     = 3'd4,
        SEC_5     = 3'd5,
        SEC_BLACK = 3'd6
    } sector_t;

    typedef struct packed {
        sector_t          sector;
        logic [CH_W-1:0]  val;
    } side_t;

endpackage

`default_nettype wire

// ===== hw/rtl/hsv_to_rgb_pixel_core.sv =====
// HSV to RGB pixel converter, top level.
// Depends on hsv2rgb_pkg and hsv2rgb_cdiv.
`timescale 1ns / 1ps
`default_nettype none

// Usage
//   Request channel: drive hue, saturation and brightness and pulse start.
//   A request is taken at every rising edge with start high and busy low.
//   busy is held low: the core takes one pixel per clock, every clock.
//   Hue is in 1/2^HUE_FRAC_BITS degree units; saturation and brightness are
//   fractions over 255. Hue of 360 degrees or more yields black.
//   Result channel: done is high for exactly one cycle with red, green,
//   blue and packed_color (red in the top byte) valid in that cycle.
//   Pipeline: a request passes 7 register stages on its way to done and
//   the output registers:
//     1 sector split, 2 saturation products, 3 level numerators,
//     4..6 constant dividers (reciprocal multiply, back multiply, fix-up),
//     7 channel select into the output registers.
//   Throughput: one pixel per clock, fixed; set by the fully pipelined
//   datapath (no path in a stage goes through more than one multiplier).
//   Results arrive in request order; the receiver cannot stall, so
//   nothing is held back and no request is ever refused.
//   Reset (rst_n low, async) drops all in-flight requests and clears done.
module hsv_to_rgb_pixel_core #(
    parameter int HUE_FRAC_BITS = 6
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic [hsv2rgb_pkg::HUE_W-1:0]  hue,
    input  wire logic [hsv2rgb_pkg::CH_W-1:0]   saturation,
    input  wire logic [hsv2rgb_pkg::CH_W-1:0]   brightness,
    output logic                                done,
    output logic [hsv2rgb_pkg::CH_W-1:0]        red,
    output logic [hsv2rgb_pkg::CH_W-1:0]        green,
    output logic [hsv2rgb_pkg::CH_W-1:0]        blue,
    output logic [hsv2rgb_pkg::PACK_W-1:0]      packed_color
);
    import hsv2rgb_pkg::*;

    // 60 degrees in hue units, and the q/t denominator 255 * span
    localparam int SPAN   = SECT_DEG << HUE_FRAC_BITS;
    localparam int REM_W  = $clog2(SPAN);
    localparam int DEN    = CHAN_MAX * SPAN;
    localparam int DEN_W  = $clog2(DEN + 1);
    localparam int NUM_W  = DEN_W + CH_W;
    localparam int PN_W   = 2 * CH_W;
    localparam int ENDV   = NUM_SECT * SPAN;
    localparam int CMP_W  = ($clog2(ENDV + 1) > HUE_W) ? $clog2(ENDV + 1) : HUE_W;
    localparam int DIV_LAT = 3;

    // valid per stage: 1..3 front end, 4..6 dividers
    logic [5:0] vld_reg;

    // stage 1: sector split
    sector_t          sec1_reg;
    logic [REM_W-1:0] rem1_reg;
    logic [CH_W-1:0]  sat1_reg;
    logic [CH_W-1:0]  val1_reg;

    // stage 2: saturation products
    logic [DEN_W-1:0] aq2_reg;
    logic [DEN_W-1:0] at2_reg;
    logic [PN_W-1:0]  pn2_reg;
    side_t            side2_reg;

    // stage 3: numerators into the dividers
    logic [NUM_W-1:0] nq3_reg;
    logic [NUM_W-1:0] nt3_reg;
    logic [PN_W-1:0]  pn3_reg;
    side_t            side3_reg;

    // sideband delay across the divider pipeline
    side_t            side_dly_reg [DIV_LAT];

    // output stage
    logic             done_reg;
    logic [CH_W-1:0]  red_reg;
    logic [CH_W-1:0]  green_reg;
    logic [CH_W-1:0]  blue_reg;

    sector_t          sec1_next;
    logic [REM_W-1:0] rem1_next;
    logic [CMP_W-1:0] hue_ext;
    logic [CMP_W-1:0] base;
    logic [CMP_W-1:0] diff;
    logic [DEN_W-1:0] aq2_next;
    logic [DEN_W-1:0] at2_next;
    logic [PN_W-1:0]  pn2_next;
    logic [NUM_W-1:0] nq3_next;
    logic [NUM_W-1:0] nt3_next;
    logic [CH_W-1:0]  q_lvl;
    logic [CH_W-1:0]  t_lvl;
    logic [CH_W-1:0]  p_lvl;
    logic [CH_W-1:0]  red_next;
    logic [CH_W-1:0]  green_next;
    logic [CH_W-1:0]  blue_next;
    side_t            side_out;

    // Sector by parallel compares against multiples of the span.
    always_comb
    begin
        hue_ext   = CMP_W'(hue);
        sec1_next = SEC_0;
        base      = '0;
        for (int k = 1; k < NUM_SECT; k++)
        begin
            if (hue_ext >= CMP_W'(k * SPAN))
            begin
                sec1_next = sector_t'(3'(k));
                base      = CMP_W'(k * SPAN);
            end
        end
        if (hue_ext >= CMP_W'(ENDV))
        begin
            sec1_next = SEC_BLACK;
        end
        diff      = hue_ext - base;
        rem1_next = diff[REM_W-1:0];
    end

    always_comb
    begin
        aq2_next = DEN_W'(rem1_reg) * DEN_W'(sat1_reg);
        at2_next = (DEN_W'(SPAN) - DEN_W'(rem1_reg)) * DEN_W'(sat1_reg);
        pn2_next = PN_W'(val1_reg) * (PN_W'(CHAN_MAX) - PN_W'(sat1_reg));
        nq3_next = NUM_W'(side2_reg.val) * (NUM_W'(DEN) - NUM_W'(aq2_reg));
        nt3_next = NUM_W'(side2_reg.val) * (NUM_W'(DEN) - NUM_W'(at2_reg));
    end

    hsv2rgb_cdiv #(
        .DIVISOR (DEN),
        .NUM_W   (NUM_W)
    ) u_div_q (
        .clk (clk),
        .num (nq3_reg),
        .quo (q_lvl)
    );

    hsv2rgb_cdiv #(
        .DIVISOR (DEN),
        .NUM_W   (NUM_W)
    ) u_div_t (
        .clk (clk),
        .num (nt3_reg),
        .quo (t_lvl)
    );

    hsv2rgb_cdiv #(
        .DIVISOR (CHAN_MAX),
        .NUM_W   (PN_W)
    ) u_div_p (
        .clk (clk),
        .num (pn3_reg),
        .quo (p_lvl)
    );

    // Per-sector channel routing.
    always_comb
    begin
        side_out = side_dly_reg[DIV_LAT-1];
        case (side_out.sector)
            SEC_0:
            begin
                red_next = side_out.val; green_next = t_lvl; blue_next = p_lvl;
            end
            SEC_1:
            begin
                red_next = q_lvl; green_next = side_out.val; blue_next = p_lvl;
            end
            SEC_2:
            begin
                red_next = p_lvl; green_next = side_out.val; blue_next = t_lvl;
            end
            SEC_3:
            begin
                red_next = p_lvl; green_next = q_lvl; blue_next = side_out.val;
            end
            SEC_4:
            begin
                red_next = t_lvl; green_next = p_lvl; blue_next = side_out.val;
            end
            SEC_5:
            begin
                red_next = side_out.val; green_next = p_lvl; blue_next = q_lvl;
            end
            default:
            begin
                red_next = '0; green_next = '0; blue_next = '0;
            end
        endcase
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            vld_reg  <= {vld_reg[4:0], start};
            done_reg <= vld_reg[5];
        end
    end

    // datapath, no reset
    always_ff @(posedge clk)
    begin
        sec1_reg         <= sec1_next;
        rem1_reg         <= rem1_next;
        sat1_reg         <= saturation;
        val1_reg         <= brightness;

        aq2_reg          <= aq2_next;
        at2_reg          <= at2_next;
        pn2_reg          <= pn2_next;
        side2_reg.sector <= sec1_reg;
        side2_reg.val    <= val1_reg;

        nq3_reg          <= nq3_next;
        nt3_reg          <= nt3_next;
        pn3_reg          <= pn2_reg;
        side3_reg        <= side2_reg;

        side_dly_reg[0]  <= side3_reg;
        for (int i = 1; i < DIV_LAT; i++)
        begin
            side_dly_reg[i] <= side_dly_reg[i-1];
        end

        red_reg          <= red_next;
        green_reg        <= green_next;
        blue_reg         <= blue_next;
    end

    assign busy         = 1'b0;
    assign done         = done_reg;
    assign red          = red_reg;
    assign green        = green_reg;
    assign blue         = blue_reg;
    assign packed_color = {red_reg, green_reg, blue_reg};

endmodule

`default_nettype wire

// ===== hw/rtl/hsv2rgb_cdiv.sv =====
// Pipelined divide by a constant: reciprocal multiply plus one correction step.
// Quotient must fit in CH_W bits. Depends on hsv2rgb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hsv2rgb_cdiv #(
    parameter int unsigned DIVISOR = 255,
    parameter int unsigned NUM_W   = 16
) (
    input  wire logic                        clk,
    input  wire logic [NUM_W-1:0]            num,
    output logic [hsv2rgb_pkg::CH_W-1:0]     quo
);
    import hsv2rgb_pkg::*;

    // floor(2^NUM_W / DIVISOR): estimate is never high and at most one low
    localparam longint unsigned RECIP = (longint'(1) << NUM_W) / DIVISOR;
    localparam int RCP_W  = $clog2(RECIP + 1);
    localparam int PROD_W = NUM_W + RCP_W;

    logic [PROD_W-1:0] prod_reg;
    logic [NUM_W-1:0]  num1_reg;
    logic [NUM_W-1:0]  num2_reg;
    logic [CH_W-1:0]   est_reg;
    logic [NUM_W-1:0]  back_reg;
    logic [CH_W-1:0]   quo_reg;

    logic [PROD_W-1:0] prod_next;
    logic [CH_W-1:0]   est_next;
    logic [NUM_W-1:0]  back_next;
    logic [NUM_W-1:0]  resid;
    logic [CH_W-1:0]   quo_next;

    always_comb
    begin
        prod_next = PROD_W'(num) * PROD_W'(RECIP);
        est_next  = prod_reg[NUM_W +: CH_W];
        back_next = NUM_W'(est_next) * NUM_W'(DIVISOR);
        resid     = num2_reg - back_reg;
        quo_next  = est_reg + CH_W'(resid >= NUM_W'(DIVISOR));
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        num1_reg <= num;
        est_reg  <= est_next;
        back_reg <= back_next;
        num2_reg <= num1_reg;
        quo_reg  <= quo_next;
    end

    assign quo = quo_reg;

endmodule

`default_nettype wire
